>>> src/trle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold run-length encoder package
// Shared widths, register indexes and types for the encoder blocks.
// ----------------------------------------------------------------------------
package trle_pkg;

  localparam int PIX_W              = 16;   // pixel field on the stream
  localparam int THR_W              = 16;   // threshold register
  localparam int LW_W               = 13;   // line width register
  localparam int COL_W              = 12;   // column, row and run fields
  localparam int LINE_LIMIT         = 1 << COL_W;
  localparam int ADDR_W             = 4;    // four 32-bit registers
  localparam int DATA_W             = 32;
  localparam int QUEUE_DEPTH        = 2;

  localparam int PIXEL_WIDTH_DEF    = 16;
  localparam int MAX_LINE_WIDTH_DEF = 4096;

  localparam logic [LW_W-1:0] LINE_WIDTH_RST = LW_W'(640);

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_SIGNED_CMP = 2'd1;
  localparam logic [1:0] REG_INVERT     = 2'd2;
  localparam logic [1:0] REG_LINE_WIDTH = 2'd3;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic             signed_cmp;
    logic             invert;
    logic [LW_W-1:0]  line_width;
  } trle_cfg_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic on;
    logic frame_start;
  } trle_cls_t;

endpackage

>>> src/trle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold run-length encoder stream interfaces
// Pixel input channel and run output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface trle_pix_if;
  import trle_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface trle_run_if;
  import trle_pkg::*;

  logic             valid;
  logic             ready;
  logic [COL_W-1:0] run_begin;
  logic [COL_W-1:0] run_end;
  logic [COL_W-1:0] run_row;

  modport source (output valid, output run_begin, output run_end, output run_row,
                  input ready);
  modport sink   (input valid, input run_begin, input run_end, input run_row,
                  output ready);
endinterface

>>> src/trle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold run-length encoder front end
// Accepts pixel beats and classifies each one as on or off.
// ----------------------------------------------------------------------------
module trle_front #(
  parameter int PIXEL_WIDTH = trle_pkg::PIXEL_WIDTH_DEF
) (
  trle_pix_if.sink             pix_i,
  input  trle_pkg::trle_cfg_t  cfg_i,
  input  logic                 push_ready_i,
  output logic                 push_valid_o,
  output trle_pkg::trle_cls_t  push_data_o
);
  import trle_pkg::*;

  localparam logic [PIXEL_WIDTH-1:0] SIGN_BIT = {1'b1, {(PIXEL_WIDTH-1){1'b0}}};

  logic [PIXEL_WIDTH-1:0] pix_val;
  logic [PIXEL_WIDTH-1:0] thr_val;
  logic [PIXEL_WIDTH-1:0] flip;
  logic                   above;

  // flip the sign bit so a signed compare becomes an unsigned one
  always_comb begin
    pix_val = PIXEL_WIDTH'(pix_i.pixel);
    thr_val = PIXEL_WIDTH'(cfg_i.threshold);
    flip    = cfg_i.signed_cmp ? SIGN_BIT : '0;
    above   = (pix_val ^ flip) > (thr_val ^ flip);
  end

  assign pix_i.ready              = push_ready_i;
  assign push_valid_o             = pix_i.valid;
  assign push_data_o.on           = above ^ cfg_i.invert;
  assign push_data_o.frame_start  = pix_i.frame_start;

endmodule

>>> src/trle_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold run-length encoder queue
// Short FIFO of classified pixels between front and back.
// ----------------------------------------------------------------------------
module trle_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  trle_pkg::trle_cls_t push_data_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output trle_pkg::trle_cls_t pop_data_o
);
  import trle_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  trle_cls_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_FULL);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> src/trle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold run-length encoder back end
// Tracks column, row and the open run; registers each emitted run.
// ----------------------------------------------------------------------------
module trle_back #(
  parameter int MAX_LINE_WIDTH = trle_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [trle_pkg::LW_W-1:0]     line_width_i,
  input  logic                          pop_valid_i,
  input  trle_pkg::trle_cls_t           pop_data_i,
  output logic                          pop_ready_o,
  trle_run_if.source                    run_o
);
  import trle_pkg::*;

  localparam int LINE_CAP = (MAX_LINE_WIDTH < LINE_LIMIT) ? MAX_LINE_WIDTH : LINE_LIMIT;
  localparam logic [LW_W-1:0] LINE_CAP_V = LW_W'(LINE_CAP);

  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] row_q, row_d;
  logic             open_q, open_d;
  logic [COL_W-1:0] start_q, start_d;
  logic             out_valid_q, out_valid_d;
  logic [COL_W-1:0] out_begin_q, out_end_q, out_row_q;
  logic [COL_W-1:0] out_begin_d, out_end_d;

  logic [LW_W-1:0]  eff_width;
  logic [COL_W-1:0] col, row, start;
  logic             open, on, eol, fire, emit;

  assign pop_ready_o = !out_valid_q || run_o.ready;
  assign fire        = pop_valid_i && pop_ready_o;

  always_comb begin
    if (line_width_i == '0) begin
      eff_width = LW_W'(1);
    end else if (line_width_i > LINE_CAP_V) begin
      eff_width = LINE_CAP_V;
    end else begin
      eff_width = line_width_i;
    end
  end

  // frame start drops any open run and restarts at column 0, row 0
  always_comb begin
    on    = pop_data_i.on;
    col   = pop_data_i.frame_start ? '0 : col_q;
    row   = pop_data_i.frame_start ? '0 : row_q;
    start = pop_data_i.frame_start ? '0 : start_q;
    open  = pop_data_i.frame_start ? 1'b0 : open_q;
    eol   = ({1'b0, col} + LW_W'(1)) >= eff_width;

    // an off pixel closes the run; an on pixel at line end closes it too
    emit        = (!on && open) || (on && eol);
    out_begin_d = (on && !open) ? col : start;
    out_end_d   = on ? col : col - COL_W'(1);

    open_d  = on && !eol;
    start_d = (on && !open) ? col : start;
    col_d   = eol ? '0 : col + COL_W'(1);
    row_d   = eol ? row + COL_W'(1) : row;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = emit;
    end else if (run_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      open_q      <= 1'b0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        col_q   <= col_d;
        row_q   <= row_d;
        open_q  <= open_d;
        start_q <= start_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_begin_q <= out_begin_d;
      out_end_q   <= out_end_d;
      out_row_q   <= row;
    end
  end

  assign run_o.valid     = out_valid_q;
  assign run_o.run_begin = out_begin_q;
  assign run_o.run_end   = out_end_q;
  assign run_o.run_row   = out_row_q;

endmodule

>>> src/threshold_run_length_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold run-length encoder
// Thresholds a raster pixel stream and emits one beat per run of on pixels.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock, sustained while run_o takes runs, and emits
// a run (begin column, end column, row) when an off pixel closes it or the
// line ends with it open. A run reaches run_o through the two-entry queue
// between the classifying front end and the run tracker, then through the
// run output register. The queue and the output register absorb short
// stalls on either side, so with no stalls the stream moves at one beat
// per clock. There is no clearing pass after reset.
// Registers (APB, byte address 4*i): threshold, signed compare, invert,
// line width. Write them only while the stream is idle.
module threshold_run_length_encoder #(
  parameter int PIXEL_WIDTH    = trle_pkg::PIXEL_WIDTH_DEF,
  parameter int MAX_LINE_WIDTH = trle_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trle_pkg::ADDR_W-1:0]   paddr,
  input  logic [trle_pkg::DATA_W-1:0]   pwdata,
  output logic [trle_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  trle_pix_if.sink                      pix_i,
  trle_run_if.source                    run_o
);
  import trle_pkg::*;

  trle_cfg_t  cfg_q;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  logic       push_valid, push_ready, pop_valid, pop_ready;
  trle_cls_t  push_data, pop_data;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= '0;
      cfg_q.signed_cmp <= 1'b0;
      cfg_q.invert     <= 1'b0;
      cfg_q.line_width <= LINE_WIDTH_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_THRESHOLD:  cfg_q.threshold  <= pwdata[THR_W-1:0];
        REG_SIGNED_CMP: cfg_q.signed_cmp <= pwdata[0];
        REG_INVERT:     cfg_q.invert     <= pwdata[0];
        REG_LINE_WIDTH: cfg_q.line_width <= pwdata[LW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD:  prdata = DATA_W'(cfg_q.threshold);
      REG_SIGNED_CMP: prdata = DATA_W'(cfg_q.signed_cmp);
      REG_INVERT:     prdata = DATA_W'(cfg_q.invert);
      REG_LINE_WIDTH: prdata = DATA_W'(cfg_q.line_width);
      default:        prdata = '0;
    endcase
  end

  trle_front #(
    .PIXEL_WIDTH (PIXEL_WIDTH)
  ) u_front (
    .pix_i        (pix_i),
    .cfg_i        (cfg_q),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_data_o  (push_data)
  );

  trle_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  trle_back #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_width_i (cfg_q.line_width),
    .pop_valid_i  (pop_valid),
    .pop_data_i   (pop_data),
    .pop_ready_o  (pop_ready),
    .run_o        (run_o)
  );

  // an empty queue always takes a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_valid |-> push_ready)
    else $error("queue empty but not ready");

  // an accepted pixel is waiting for the back end on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> pop_valid)
    else $error("accepted pixel lost before back end");

  // a run never ends before it begins
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_o.valid |-> (run_o.run_end >= run_o.run_begin))
    else $error("run end precedes run begin");

endmodule

>>> sim/run_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run list checker
// Watches the register port and both stream channels of the threshold
// run-length encoder, predicts the run beats from the accepted pixels and
// compares each run beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module run_list_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [trle_pkg::ADDR_W-1:0]   paddr,
  input  logic [trle_pkg::DATA_W-1:0]   pwdata,
  trle_pix_if                           pix_i,
  trle_run_if                           run_i,
  output int                            pending_o,
  output int                            errors_o
);
  import trle_pkg::*;

  localparam int WIDTH_CAP = (MAX_LINE_WIDTH_DEF < LINE_LIMIT) ? MAX_LINE_WIDTH_DEF
                                                               : LINE_LIMIT;

  typedef struct packed {
    logic [COL_W-1:0] first_col;
    logic [COL_W-1:0] last_col;
    logic [COL_W-1:0] line_row;
  } run_span_t;

  run_span_t        runs_due[$];
  int               mismatches = 0;

  logic [THR_W-1:0] cfg_thr    = '0;
  logic             cfg_signed = 1'b0;
  logic             cfg_invert = 1'b0;
  logic [LW_W-1:0]  cfg_width  = LINE_WIDTH_RST;

  logic [COL_W-1:0] col_q   = '0;
  logic [COL_W-1:0] row_q   = '0;
  logic             open_q  = 1'b0;
  logic [COL_W-1:0] start_q = '0;

  function automatic logic pixel_lit(input logic [PIX_W-1:0] px);
    logic above;
    if (cfg_signed) begin
      above = $signed(px) > $signed(cfg_thr);
    end else begin
      above = px > cfg_thr;
    end
    return cfg_invert ? !above : above;
  endfunction

  task automatic take_pixel(input logic [PIX_W-1:0] px, input logic frame_start);
    logic      lit;
    int        col;
    int        width;
    run_span_t span;
    lit = pixel_lit(px);
    if (frame_start) begin
      // drop any open run, restart at column 0, row 0
      col_q   = '0;
      row_q   = '0;
      open_q  = 1'b0;
      start_q = '0;
    end
    col   = int'(col_q);
    width = (cfg_width == '0) ? 1 : int'(cfg_width);
    if (width > WIDTH_CAP) width = WIDTH_CAP;

    if (lit && !open_q) begin
      start_q = COL_W'(col);
      open_q  = 1'b1;
    end else if (!lit && open_q) begin
      span = '{first_col: start_q, last_col: COL_W'(col - 1), line_row: row_q};
      runs_due.insert(runs_due.size(), span);
      open_q = 1'b0;
    end

    // a column at or past the last one ends the line
    if (col + 1 >= width) begin
      if (open_q) begin
        span = '{first_col: start_q, last_col: COL_W'(col), line_row: row_q};
        runs_due.insert(runs_due.size(), span);
        open_q = 1'b0;
      end
      col_q = '0;
      row_q = row_q + 1'b1;
    end else begin
      col_q = COL_W'(col + 1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    run_span_t due;
    if (!rst_ni) begin
      cfg_thr    = '0;
      cfg_signed = 1'b0;
      cfg_invert = 1'b0;
      cfg_width  = LINE_WIDTH_RST;
      col_q      = '0;
      row_q      = '0;
      open_q     = 1'b0;
      start_q    = '0;
      runs_due.delete();
      pending_o <= 0;
      errors_o  <= mismatches;
    end else begin
      if (run_i.valid && run_i.ready) begin
        if (runs_due.size() == 0) begin
          $error("run beat with none expected: begin %0d end %0d row %0d",
                 run_i.run_begin, run_i.run_end, run_i.run_row);
          mismatches++;
        end else begin
          due = runs_due.pop_front();
          if (run_i.run_begin !== due.first_col) begin
            $error("run_begin: expected %0d, actual %0d", due.first_col, run_i.run_begin);
            mismatches++;
          end
          if (run_i.run_end !== due.last_col) begin
            $error("run_end: expected %0d, actual %0d", due.last_col, run_i.run_end);
            mismatches++;
          end
          if (run_i.run_row !== due.line_row) begin
            $error("run_row: expected %0d, actual %0d", due.line_row, run_i.run_row);
            mismatches++;
          end
        end
      end

      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_THRESHOLD:  cfg_thr    = pwdata[THR_W-1:0];
          REG_SIGNED_CMP: cfg_signed = pwdata[0];
          REG_INVERT:     cfg_invert = pwdata[0];
          REG_LINE_WIDTH: cfg_width  = pwdata[LW_W-1:0];
          default: ;
        endcase
      end

      if (pix_i.valid && pix_i.ready) begin
        take_pixel(pix_i.pixel, pix_i.frame_start);
      end

      pending_o <= runs_due.size();
      errors_o  <= mismatches;
    end
  end

endmodule

>>> sim/tb_threshold_run_length_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold run-length encoder testbench
// Drives pixel beats and register writes into the encoder, stalls both
// channels at random and leaves prediction and comparison to the run list
// checker; prints the verdict once every predicted run has been seen.
// ----------------------------------------------------------------------------
module tb_threshold_run_length_encoder;
  import trle_pkg::*;

  localparam int HALF_HI      = 6;
  localparam int HALF_LO      = 6;
  localparam int RST_CYCLES   = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT     = 37;
  localparam int STALL_LIMIT  = 1000;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic              px_valid = 1'b0;
  logic [PIX_W-1:0]  px_data  = '0;
  logic              px_fs    = 1'b0;
  logic              rx_ready = 1'b0;
  logic              steady   = 1'b0;   // no idling on either side

  logic [THR_W-1:0]  cur_thr  = '0;
  int                pending;
  int                errors;
  int                quiet_cycles = 0;

  trle_pix_if pix_bus ();
  trle_run_if run_bus ();

  assign pix_bus.valid       = px_valid;
  assign pix_bus.pixel       = px_data;
  assign pix_bus.frame_start = px_fs;
  assign run_bus.ready       = rx_ready;

  threshold_run_length_encoder uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (pix_bus),
    .run_o   (run_bus)
  );

  run_list_checker chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pix_i     (pix_bus),
    .run_i     (run_bus),
    .pending_o (pending),
    .errors_o  (errors)
  );

  always begin
    #HALF_LO clk_i = 1'b1;
    #HALF_HI clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    rx_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if ((pix_bus.valid && pix_bus.ready) || (run_bus.valid && run_bus.ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      px_valid <= 1'b0;
      px_data  <= PIX_W'($urandom());
      px_fs    <= 1'($urandom_range(0, 1));
      @(posedge clk_i);
    end
    px_valid <= 1'b1;
    px_data  <= px;
    px_fs    <= fs;
    do @(posedge clk_i); while (!pix_bus.ready);
  endtask

  // hold the sender until every predicted run is out, then let the pipe drain
  task automatic settle();
    px_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_setup(input logic [THR_W-1:0] thr, input logic sgn,
                            input logic inv, input logic [LW_W-1:0] width);
    settle();
    write_reg(REG_THRESHOLD,  DATA_W'(thr));
    write_reg(REG_SIGNED_CMP, DATA_W'(sgn));
    write_reg(REG_INVERT,     DATA_W'(inv));
    write_reg(REG_LINE_WIDTH, DATA_W'(width));
    cur_thr = thr;
  endtask

  // pixels that repeat often, so runs of some length form, with values
  // around the threshold and at the ends of the range mixed in
  task automatic stream_pixels(input int count, input int fs_pct);
    logic [PIX_W-1:0] px;
    int               pick;
    px = PIX_W'($urandom());
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        px = px;
      end else if (pick < 70) begin
        px = cur_thr + PIX_W'($urandom_range(0, 2)) - 1'b1;
      end else if (pick < 78) begin
        case ($urandom_range(0, 3))
          0:       px = '0;
          1:       px = '1;
          2:       px = {1'b0, {(PIX_W-1){1'b1}}};
          default: px = {1'b1, {(PIX_W-1){1'b0}}};
        endcase
      end else begin
        px = PIX_W'($urandom());
      end
      send_pixel(px, (k == 0) || ($urandom_range(0, 99) < fs_pct));
    end
  endtask

  initial begin
    logic [THR_W-1:0] thr;
    logic [LW_W-1:0]  width;

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setup: threshold 0, unsigned, 640-pixel lines
    send_pixel(16'h0001, 1'b1);
    send_pixel(16'h0000, 1'b0);

    // unsigned, threshold at mid-range, 8-pixel lines; equal is off
    load_setup(16'h8000, 1'b0, 1'b0, 13'd8);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h8000, 1'b0);
    send_pixel(16'h8001, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    // frame start while a run is open drops it
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'h8001, 1'b0);
    send_pixel(16'h8001, 1'b0);
    send_pixel(16'h8001, 1'b0);

    // shrink the line under an open run: the next pixel ends the line
    load_setup(16'h8000, 1'b0, 1'b0, 13'd3);
    send_pixel(16'h8001, 1'b0);

    // signed compare against -1
    load_setup(16'hFFFF, 1'b1, 1'b0, 13'd4);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'h8000, 1'b0);
    send_pixel(16'h7FFF, 1'b0);
    send_pixel(16'hFFFF, 1'b0);

    // zero line width acts as one, inverted signed compare
    load_setup(16'h0000, 1'b1, 1'b1, 13'd0);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'h8000, 1'b0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'hFFFF, 1'b1);

    // oversized width clamps to the longest line
    load_setup(16'h4000, 1'b0, 1'b0, 13'h1FFF);
    stream_pixels(200, 0);

    // one-pixel lines, a new row on every pixel
    load_setup(THR_W'($urandom()), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               13'd1);
    stream_pixels(200, 0);

    for (int seg = 0; seg < 10; seg++) begin
      case ($urandom_range(0, 5))
        0:       thr = '0;
        1:       thr = '1;
        2:       thr = 16'h8000;
        3:       thr = 16'h7FFF;
        default: thr = THR_W'($urandom());
      endcase
      case ($urandom_range(0, 9))
        0:       width = 13'd1;
        1:       width = 13'd2;
        2:       width = 13'd0;
        default: width = LW_W'($urandom_range(3, 40));
      endcase
      load_setup(thr, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), width);
      steady <= (seg == 3);
      stream_pixels($urandom_range(80, 130), 3);
    end

    settle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/trle_pkg.sv
src/trle_if.sv
src/trle_front.sv
src/trle_queue.sv
src/trle_back.sv
src/threshold_run_length_encoder.sv
sim/run_list_checker.sv
sim/tb_threshold_run_length_encoder.sv
